FILE: hdl/ssnco_pkg.sv
// ssnco_pkg: shared types, constants and the sine magnitude function for the
// stereo sine oscillator. No dependencies.
`default_nettype none

package ssnco_pkg;

    // default geometry
    localparam int unsigned BUFFER_LEN_DEF       = 512;
    localparam int unsigned SINE_TABLE_DEPTH_DEF = 1024;
    localparam int unsigned PHASE_BITS_DEF       = 32;

    // result queue depth, power of two
    localparam int unsigned QUEUE_DEPTH = 8;

    // configuration register reset values
    localparam logic [31:0] TARGET_LEFT_RST  = 32'd25643188;
    localparam logic [31:0] TARGET_RIGHT_RST = 32'd38177487;

    // glide weight taken from the target, 0.05 in Q0.16
    localparam logic [12:0] GLIDE_TAKE  = 13'd3277;
    localparam int unsigned GLIDE_SHIFT = 16;

    // volume and amplitude limits
    localparam logic [15:0] FULL_VOLUME = 16'h8000;
    localparam logic [14:0] MAX_MAG     = 15'd32767;

    // quarter turn in radians, Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_TARGET_LEFT  = 1'b0,
        CFG_TARGET_RIGHT = 1'b1
    } t_cfg_idx;

    // control bits that travel with a request down the pipeline
    typedef struct packed {
        logic valid;
        logic first;
    } t_stage;

    // one result as held in the output queue
    typedef struct packed {
        logic        first;
        logic [15:0] left;
        logic [15:0] right;
    } t_result;

    // magnitude of the sine for quarter-wave entry k of 2^qbits entries,
    // amplitude 32767, from an eleventh-order odd series in Q30
    function automatic logic [14:0] sine_mag(input int unsigned k,
                                             input int unsigned qbits);
        logic        [63:0] r;
        logic        [63:0] x;
        logic        [63:0] x2;
        logic        [63:0] term;
        logic signed [63:0] sum;
        logic        [63:0] mag;
        r    = 64'(k) << (30 - qbits);
        x    = (r * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - signed'(term);
        if (sum < 0) begin
            sum = '0;
        end
        mag = ((64'(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
        if (mag > 64'(MAX_MAG)) begin
            mag = 64'(MAX_MAG);
        end
        return mag[14:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ssnco_glide.sv
// ssnco_glide: per-buffer position counter and the two phase steps that
// glide toward their targets at the start of each buffer. Uses ssnco_pkg.
`default_nettype none

module ssnco_glide #(
    parameter int unsigned BUFFER_LEN = ssnco_pkg::BUFFER_LEN_DEF,
    parameter int unsigned PHASE_BITS = ssnco_pkg::PHASE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic [31:0]           i_target_left,
    input  wire logic [31:0]           i_target_right,
    output logic      [PHASE_BITS-1:0] o_step_left,
    output logic      [PHASE_BITS-1:0] o_step_right,
    output logic                       o_first
);

    localparam int unsigned POS_W = (BUFFER_LEN > 1) ? $clog2(BUFFER_LEN) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(BUFFER_LEN - 1);

    logic [POS_W-1:0]      r_pos;
    logic [POS_W-1:0]      n_pos;
    logic [PHASE_BITS-1:0] r_step_left;
    logic [PHASE_BITS-1:0] r_step_right;
    logic [PHASE_BITS-1:0] n_step_left;
    logic [PHASE_BITS-1:0] n_step_right;

    // step + floor((target - step) * 0.05), same as step*0.95 + target*0.05
    function automatic logic [PHASE_BITS-1:0] glide(input logic [PHASE_BITS-1:0] step,
                                                    input logic [31:0] target);
        logic signed [PHASE_BITS:0]    diff;
        logic signed [PHASE_BITS+13:0] prod;
        logic signed [PHASE_BITS+13:0] shifted;
        diff    = signed'({1'b0, PHASE_BITS'(target)}) - signed'({1'b0, step});
        prod    = diff * signed'(ssnco_pkg::GLIDE_TAKE);
        shifted = prod >>> ssnco_pkg::GLIDE_SHIFT;
        return step + shifted[PHASE_BITS-1:0];
    endfunction

    // start of buffer
    assign o_first = (r_pos == '0);

    // next position and steps
    always_comb begin
        n_pos        = r_pos;
        n_step_left  = r_step_left;
        n_step_right = r_step_right;
        if (i_accept) begin
            n_pos = (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
            if (o_first) begin
                n_step_left  = glide(r_step_left, i_target_left);
                n_step_right = glide(r_step_right, i_target_right);
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_step_left  <= '0;
            r_step_right <= '0;
        end else begin
            r_pos        <= n_pos;
            r_step_left  <= n_step_left;
            r_step_right <= n_step_right;
        end
    end

    assign o_step_left  = r_step_left;
    assign o_step_right = r_step_right;

endmodule

`default_nettype wire

FILE: hdl/ssnco_osc.sv
// ssnco_osc: one channel: phase accumulator, quarter-wave sine lookup and
// volume scaling, three register stages. Uses ssnco_pkg.
`default_nettype none

module ssnco_osc #(
    parameter int unsigned SINE_TABLE_DEPTH = ssnco_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int unsigned PHASE_BITS       = ssnco_pkg::PHASE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_adv,
    input  wire logic [PHASE_BITS-1:0] i_step,
    input  wire logic [15:0]           i_vol,
    output logic      [15:0]           o_sample
);

    localparam int unsigned IDX_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned LOG2Q  = IDX_W - 2;
    localparam int unsigned QUARTER = SINE_TABLE_DEPTH / 4;

    logic [PHASE_BITS-1:0] r_phase;
    logic [15:0]           r_vol2;
    logic [14:0]           r_mag3;
    logic                  r_neg3;
    logic [15:0]           r_vol3;
    logic [15:0]           r_sample4;

    logic [14:0]      w_rom [QUARTER];
    logic [IDX_W-1:0] w_idx;
    logic [1:0]       w_quad;
    logic [LOG2Q:0]   w_rr;
    logic [14:0]      w_mag;
    logic [15:0]      w_vol_sat;
    logic [30:0]      w_prod;
    logic [15:0]      w_scaled;

    // quarter-wave table, constant
    for (genvar g = 0; g < QUARTER; g++) begin : g_rom
        assign w_rom[g] = ssnco_pkg::sine_mag(g, LOG2Q);
    end

    // phase accumulator, natural wrap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_adv) begin
            r_phase <= r_phase + i_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_vol2 <= i_vol;
        end
    end

    // fold the table index into the first quadrant
    assign w_idx  = r_phase[PHASE_BITS-1 -: IDX_W];
    assign w_quad = w_idx[IDX_W-1 -: 2];
    assign w_rr   = w_quad[0] ? ({1'b1, {LOG2Q{1'b0}}} - {1'b0, w_idx[LOG2Q-1:0]})
                              : {1'b0, w_idx[LOG2Q-1:0]};
    assign w_mag  = w_rr[LOG2Q] ? ssnco_pkg::MAX_MAG : w_rom[w_rr[LOG2Q-1:0]];

    // volume saturates at full scale
    assign w_vol_sat = (r_vol2 > ssnco_pkg::FULL_VOLUME) ? ssnco_pkg::FULL_VOLUME : r_vol2;

    always_ff @(posedge i_clk) begin
        r_mag3 <= w_mag;
        r_neg3 <= w_quad[1];
        r_vol3 <= w_vol_sat;
    end

    // scale, truncating toward zero, then restore the sign
    assign w_prod   = 31'(r_mag3) * 31'(r_vol3);
    assign w_scaled = w_prod[30:15];

    always_ff @(posedge i_clk) begin
        r_sample4 <= r_neg3 ? (16'd0 - w_scaled) : w_scaled;
    end

    assign o_sample = r_sample4;

endmodule

`default_nettype wire

FILE: hdl/ssnco_out_fifo.sv
// ssnco_out_fifo: small show-ahead queue that holds finished results until
// they are taken. Uses ssnco_pkg for the result type.
`default_nettype none

module ssnco_out_fifo #(
    parameter int unsigned DEPTH = ssnco_pkg::QUEUE_DEPTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_wr,
    input  wire ssnco_pkg::t_result  i_wdata,
    input  wire logic                i_rd,
    output ssnco_pkg::t_result       o_rdata,
    output logic                     o_valid,
    output logic                     o_full
);

    localparam int unsigned PTR_W  = $clog2(DEPTH);
    localparam int unsigned FILL_W = $clog2(DEPTH + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

    ssnco_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [FILL_W-1:0]  r_fill;
    logic               w_rd;

    assign o_valid = (r_fill != '0);
    assign o_full  = (r_fill == FILL_MAX);
    assign w_rd    = i_rd && o_valid;
    assign o_rdata = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_fill <= r_fill + FILL_W'(i_wr) - FILL_W'(w_rd);
        end
    end

endmodule

`default_nettype wire

FILE: hdl/stereo_sine_nco_with_glide_core.sv
// stereo_sine_nco_with_glide_core: top level of the stereo sine oscillator.
// Depends on ssnco_pkg, ssnco_glide, ssnco_osc and ssnco_out_fifo.
`default_nettype none

// Two-channel DDS sine oscillator. Each accepted request (a pair of Q1.15
// volumes) yields exactly one result: left and right signed samples plus a
// flag that marks the first sample of a buffer of BUFFER_LEN samples, where
// both phase steps have just glided 5% toward their target registers. One
// request is taken every clock cycle while ready is high; a request passes the
// input, phase, table and sample registers into the output queue, and up to
// QUEUE_DEPTH (8) requests may be in flight or waiting in the output queue
// before ready drops. The glide update and the phase accumulator set that
// rate. SINE_TABLE_DEPTH must be a power of two; the table is stored as one
// quarter wave. The user must write targets through the plain write port only
// while no request is outstanding; the block itself does not enforce this.
module stereo_sine_nco_with_glide_core #(
    parameter int unsigned BUFFER_LEN       = ssnco_pkg::BUFFER_LEN_DEF,
    parameter int unsigned SINE_TABLE_DEPTH = ssnco_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int unsigned PHASE_BITS       = ssnco_pkg::PHASE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_volume_left,
    input  wire logic [15:0] i_volume_right,
    // result channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_sample_left,
    output logic [15:0]      o_sample_right,
    output logic             o_buffer_first,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_wdata
);

    localparam int unsigned QD      = ssnco_pkg::QUEUE_DEPTH;
    localparam int unsigned CRED_W  = $clog2(QD + 1);
    localparam logic [CRED_W-1:0] CRED_MAX = CRED_W'(QD);

    logic [31:0]        r_target_left;
    logic [31:0]        r_target_right;
    logic [CRED_W-1:0]  r_credit;
    ssnco_pkg::t_stage  r_s1;
    ssnco_pkg::t_stage  r_s2;
    ssnco_pkg::t_stage  r_s3;
    ssnco_pkg::t_stage  r_s4;
    logic [15:0]        r_vol_left;
    logic [15:0]        r_vol_right;

    logic                  w_accept;
    logic                  w_pop;
    logic                  w_first;
    logic [PHASE_BITS-1:0] w_step_left;
    logic [PHASE_BITS-1:0] w_step_right;
    logic [15:0]           w_sample_left;
    logic [15:0]           w_sample_right;
    ssnco_pkg::t_result    w_wdata;
    ssnco_pkg::t_result    w_rdata;
    logic                  w_fifo_valid;
    logic                  w_fifo_full;

    // handshakes
    assign o_ready  = (r_credit < CRED_MAX);
    assign w_accept = i_valid && o_ready;
    assign w_pop    = w_fifo_valid && i_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_left  <= ssnco_pkg::TARGET_LEFT_RST;
            r_target_right <= ssnco_pkg::TARGET_RIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (ssnco_pkg::t_cfg_idx'(i_cfg_idx))
                ssnco_pkg::CFG_TARGET_LEFT:  r_target_left  <= i_cfg_wdata;
                ssnco_pkg::CFG_TARGET_RIGHT: r_target_right <= i_cfg_wdata;
            endcase
        end
    end

    // requests in flight or queued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + CRED_W'(w_accept) - CRED_W'(w_pop);
        end
    end

    // step glide and buffer position
    ssnco_glide #(
        .BUFFER_LEN (BUFFER_LEN),
        .PHASE_BITS (PHASE_BITS)
    ) u_glide (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_target_left  (r_target_left),
        .i_target_right (r_target_right),
        .o_step_left    (w_step_left),
        .o_step_right   (w_step_right),
        .o_first        (w_first)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_vol_left  <= i_volume_left;
            r_vol_right <= i_volume_right;
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
            r_s4 <= '0;
        end else begin
            r_s1 <= '{valid: w_accept, first: w_first};
            r_s2 <= r_s1;
            r_s3 <= r_s2;
            r_s4 <= r_s3;
        end
    end

    // channels
    ssnco_osc #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PHASE_BITS       (PHASE_BITS)
    ) u_osc_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (r_s1.valid),
        .i_step   (w_step_left),
        .i_vol    (r_vol_left),
        .o_sample (w_sample_left)
    );

    ssnco_osc #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PHASE_BITS       (PHASE_BITS)
    ) u_osc_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (r_s1.valid),
        .i_step   (w_step_right),
        .i_vol    (r_vol_right),
        .o_sample (w_sample_right)
    );

    // result queue
    assign w_wdata = '{first: r_s4.first, left: w_sample_left, right: w_sample_right};

    ssnco_out_fifo #(
        .DEPTH (QD)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (r_s4.valid),
        .i_wdata (w_wdata),
        .i_rd    (i_ready),
        .o_rdata (w_rdata),
        .o_valid (w_fifo_valid),
        .o_full  (w_fifo_full)
    );

    assign o_valid        = w_fifo_valid;
    assign o_sample_left  = w_rdata.left;
    assign o_sample_right = w_rdata.right;
    assign o_buffer_first = w_rdata.first;

`ifndef SYNTHESIS
    // credit scheme keeps the queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4.valid |-> !w_fifo_full)
        else $error("result written into a full queue");

    // a request enters the pipeline only through the handshake
    a_s1_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1.valid |-> $past(i_valid && o_ready))
        else $error("pipeline stage filled without an accepted request");

    // a queued result is always covered by a credit
    a_credit_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fifo_valid |-> (r_credit != '0))
        else $error("queued result without outstanding credit");

    // credits only return when a result leaves
    a_credit_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_accept && !w_pop) |=> $stable(r_credit))
        else $error("credit count moved without a handshake");
`endif

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for stereo_sine_nco_with_glide_core, with its own
// sample predictor, directed and random volume requests and random idling on both sides
// depends on ssnco_pkg and the core RTL only
module testbench;

    localparam int unsigned BUF_LEN     = ssnco_pkg::BUFFER_LEN_DEF;
    localparam int unsigned SINE_DEPTH  = ssnco_pkg::SINE_TABLE_DEPTH_DEF;
    localparam int unsigned PHASE_W     = ssnco_pkg::PHASE_BITS_DEF;
    localparam int unsigned SINE_BITS   = $clog2(SINE_DEPTH);
    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    // glide weights in Q0.16, keep plus take is exactly one
    localparam longint unsigned STEP_KEEP_Q16 = 64'd62259;
    localparam longint unsigned STEP_TAKE_Q16 = 64'd3277;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PRINT_CAP   = 60;

    typedef struct {
        logic [15:0]        vol_l;
        logic [15:0]        vol_r;
        bit                 typed;
        ssnco_pkg::t_result want;
    } t_row;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        o_ready;
    logic [15:0] i_volume_left  = '0;
    logic [15:0] i_volume_right = '0;
    logic        o_valid;
    logic        i_ready        = 1'b0;
    logic [15:0] o_sample_left;
    logic [15:0] o_sample_right;
    logic        o_buffer_first;
    logic        i_cfg_we       = 1'b0;
    logic [0:0]  i_cfg_idx      = ssnco_pkg::CFG_TARGET_LEFT;
    logic [31:0] i_cfg_wdata    = '0;

    // oscillator copy kept by the predictor
    int          sine_rom [SINE_DEPTH];
    logic [31:0] osc_target_l = ssnco_pkg::TARGET_LEFT_RST;
    logic [31:0] osc_target_r = ssnco_pkg::TARGET_RIGHT_RST;
    logic [31:0] osc_phase_l  = '0;
    logic [31:0] osc_phase_r  = '0;
    logic [31:0] osc_step_l   = '0;
    logic [31:0] osc_step_r   = '0;
    int unsigned osc_pos      = 0;

    ssnco_pkg::t_result expected_pairs [$];
    t_row               directed_rows [$];
    bit                 typed_row  = 1'b0;
    ssnco_pkg::t_result typed_pair = '0;
    bit          steady     = 1'b0;
    int unsigned fault_count   = 0;
    int unsigned requests_seen = 0;
    int unsigned results_seen  = 0;
    int unsigned buffer_starts = 0;
    int unsigned over_scale    = 0;
    int unsigned settings_used = 0;
    int unsigned cycle_count   = 0;

    stereo_sine_nco_with_glide_core #(
        .BUFFER_LEN       (BUF_LEN),
        .SINE_TABLE_DEPTH (SINE_DEPTH),
        .PHASE_BITS       (PHASE_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_volume_left  (i_volume_left),
        .i_volume_right (i_volume_right),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sample_left  (o_sample_left),
        .o_sample_right (o_sample_right),
        .o_buffer_first (o_buffer_first),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // full-wave sine entry, amplitude 32767, odd series in Q30 on the folded quadrant
    function automatic int sine_value(int unsigned k);
        longint unsigned turn, r, x, x2, term, mag;
        longint          sum;
        int unsigned     quad;
        int unsigned     n;
        turn = (64'(k) << 32) / SINE_DEPTH;
        quad = int'((turn >> 30) & 64'd3);
        r    = turn & (Q30_ONE - 1);
        if (quad[0]) begin
            r = Q30_ONE - r;
        end
        x    = (r * ssnco_pkg::HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (n = 1; n <= 5; n++) begin
            term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
            if (n[0]) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        mag = (64'(sum) * 64'd32767 + (Q30_ONE >> 1)) >> 30;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        return quad[1] ? -int'(mag) : int'(mag);
    endfunction

    // one glide step toward the target, truncating
    function automatic logic [31:0] glided(logic [31:0] step, logic [31:0] target);
        logic [63:0] mix;
        mix = 64'(step) * STEP_KEEP_Q16 + 64'(target) * STEP_TAKE_Q16;
        return mix[47:16];
    endfunction

    // sine at the phase scaled by a saturated Q1.15 volume, truncated toward zero
    function automatic logic [15:0] scaled_sine(logic [31:0] phase, logic [15:0] volume);
        int          s;
        int unsigned amp, gain, level;
        s     = sine_rom[phase[PHASE_W-1 -: SINE_BITS]];
        gain  = (volume > ssnco_pkg::FULL_VOLUME) ? ssnco_pkg::FULL_VOLUME : volume;
        amp   = (s < 0) ? -s : s;
        level = (amp * gain) >> 15;
        if (s < 0) begin
            level = 0 - level;
        end
        return level[15:0];
    endfunction

    // advance both oscillators by one sample and return the expected pair
    function automatic ssnco_pkg::t_result next_sample_pair(logic [15:0] vol_l,
                                                            logic [15:0] vol_r);
        ssnco_pkg::t_result pair;
        pair.first = (osc_pos == 0);
        if (pair.first) begin
            osc_step_l = glided(osc_step_l, osc_target_l);
            osc_step_r = glided(osc_step_r, osc_target_r);
        end
        osc_phase_l = osc_phase_l + osc_step_l;
        osc_phase_r = osc_phase_r + osc_step_r;
        pair.left   = scaled_sine(osc_phase_l, vol_l);
        pair.right  = scaled_sine(osc_phase_r, vol_r);
        osc_pos     = (osc_pos + 1) % BUF_LEN;
        return pair;
    endfunction

    function automatic logic [15:0] random_volume();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            return 16'd0;
        end
        if (pick < 16) begin
            return ssnco_pkg::FULL_VOLUME;
        end
        // full 16-bit range, so above full scale appears too
        if (pick < 26) begin
            return 16'($urandom_range(65535));
        end
        return 16'($urandom_range(32768));
    endfunction

    task automatic report_mismatch(string what);
        fault_count++;
        if (fault_count <= PRINT_CAP) begin
            $display("[%0t] mismatch on result %0d: %s", $time, results_seen, what);
        end
    endtask

    task automatic add_row(logic [15:0] vol_l, logic [15:0] vol_r, bit typed,
                           logic first, logic [15:0] left_smp, logic [15:0] right_smp);
        t_row row;
        row.vol_l      = vol_l;
        row.vol_r      = vol_r;
        row.typed      = typed;
        row.want.first = first;
        row.want.left  = left_smp;
        row.want.right = right_smp;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // present one request, idling first at random, and hold it until taken
    task automatic push_volumes(logic [15:0] vol_l, logic [15:0] vol_r, bit typed,
                                ssnco_pkg::t_result want);
        while (!steady && $urandom_range(99) < 32) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_volume_left  <= vol_l;
        i_volume_right <= vol_r;
        typed_row      <= typed;
        typed_pair     <= want;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_random(int unsigned count);
        int unsigned i;
        for (i = 0; i < count; i++) begin
            push_volumes(random_volume(), random_volume(), 1'b0, '0);
        end
    endtask

    // hold off the sender until every expected pair has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (expected_pairs.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic write_targets(logic [31:0] tgt_left, logic [31:0] tgt_right);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= ssnco_pkg::CFG_TARGET_LEFT;
        i_cfg_wdata <= tgt_left;
        @(posedge i_clk);
        i_cfg_idx   <= ssnco_pkg::CFG_TARGET_RIGHT;
        i_cfg_wdata <= tgt_right;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        osc_target_l = tgt_left;
        osc_target_r = tgt_right;
        settings_used++;
    endtask

    // result checking first, then prediction for a request taken at this edge
    always @(posedge i_clk) begin
        ssnco_pkg::t_result got_pair;
        ssnco_pkg::t_result want_pair;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got_pair.first = o_buffer_first;
                got_pair.left  = o_sample_left;
                got_pair.right = o_sample_right;
                if (expected_pairs.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    want_pair = expected_pairs.pop_front();
                    if (got_pair.left !== want_pair.left) begin
                        report_mismatch($sformatf("left got %0d want %0d",
                            $signed(got_pair.left), $signed(want_pair.left)));
                    end
                    if (got_pair.right !== want_pair.right) begin
                        report_mismatch($sformatf("right got %0d want %0d",
                            $signed(got_pair.right), $signed(want_pair.right)));
                    end
                    if (got_pair.first !== want_pair.first) begin
                        report_mismatch($sformatf("buffer_first got %b want %b",
                            got_pair.first, want_pair.first));
                    end
                    if (want_pair.first) begin
                        buffer_starts++;
                    end
                end
                results_seen++;
            end
            if (i_valid && o_ready) begin
                want_pair = next_sample_pair(i_volume_left, i_volume_right);
                if (typed_row) begin
                    want_pair = typed_pair;
                end
                if (i_volume_left > ssnco_pkg::FULL_VOLUME ||
                    i_volume_right > ssnco_pkg::FULL_VOLUME) begin
                    over_scale++;
                end
                expected_pairs.insert(expected_pairs.size(), want_pair);
                requests_seen++;
            end
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        i_ready <= steady || ($urandom_range(99) >= 32);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_pairs.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned k;
        for (k = 0; k < SINE_DEPTH; k++) begin
            sine_rom[k] = sine_value(k);
        end

        // first pair after reset sits at table entry zero and starts a buffer
        add_row(16'h8000, 16'h8000, 1'b1, 1'b1, 16'd0, 16'd0);
        add_row(16'h0000, 16'h0000, 1'b1, 1'b0, 16'd0, 16'd0);
        // volumes above full scale saturate
        add_row(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 16'd0, 16'd0);
        add_row(16'h7FFF, 16'h8001, 1'b0, 1'b0, 16'd0, 16'd0);
        add_row(16'h8001, 16'h7FFF, 1'b0, 1'b0, 16'd0, 16'd0);
        add_row(16'hAAAA, 16'h5555, 1'b0, 1'b0, 16'd0, 16'd0);
        add_row(16'h5555, 16'hAAAA, 1'b0, 1'b0, 16'd0, 16'd0);
        add_row(16'h0001, 16'hFFFE, 1'b0, 1'b0, 16'd0, 16'd0);
        add_row(16'h8000, 16'h0000, 1'b0, 1'b0, 16'd0, 16'd0);
        add_row(16'h0000, 16'h8000, 1'b0, 1'b0, 16'd0, 16'd0);
        add_row(16'h4000, 16'hC000, 1'b0, 1'b0, 16'd0, 16'd0);
        add_row(16'h0000, 16'h0000, 1'b1, 1'b0, 16'd0, 16'd0);
        add_row(16'hFFFF, 16'h0001, 1'b0, 1'b0, 16'd0, 16'd0);
        add_row(16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 16'd0, 16'd0);
        add_row(16'h8000, 16'h8000, 1'b0, 1'b0, 16'd0, 16'd0);
        add_row(16'h0100, 16'hFF00, 1'b0, 1'b0, 16'd0, 16'd0);
        add_row(16'h00FF, 16'h0FF0, 1'b0, 1'b0, 16'd0, 16'd0);
        add_row(16'h0000, 16'h0000, 1'b1, 1'b0, 16'd0, 16'd0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests with the reset targets
        foreach (directed_rows[r]) begin
            push_volumes(directed_rows[r].vol_l, directed_rows[r].vol_r,
                         directed_rows[r].typed, directed_rows[r].want);
        end

        // both targets at zero
        drain_results();
        write_targets(32'h0000_0000, 32'h0000_0000);
        send_random(250);

        // both targets at full scale, glide at the next buffer start, calm stretch
        drain_results();
        write_targets(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_random(100);
        steady <= 1'b1;
        send_random(150);
        steady <= 1'b0;
        send_random(150);

        // random targets
        drain_results();
        write_targets($urandom, $urandom);
        send_random(200);

        // targets just above the current steps so the glide stalls short
        drain_results();
        write_targets(osc_step_l + 32'd5, osc_step_r + 32'd9);
        send_random(280);

        drain_results();
        repeat (16) @(posedge i_clk);

        $display("%0d volume requests over %0d target settings, %0d sample pairs checked",
                 requests_seen, settings_used, results_seen);
        $display("%0d buffer starts with glide, %0d requests above full scale",
                 buffer_starts, over_scale);
        if (fault_count == 0 && expected_pairs.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: stereo_sine_nco_with_glide_core.f
hdl/ssnco_pkg.sv
hdl/ssnco_glide.sv
hdl/ssnco_osc.sv
hdl/ssnco_out_fifo.sv
hdl/stereo_sine_nco_with_glide_core.sv
dv/testbench.sv
